// ===== rtl/utf8_invisible_char_filter_defines.svh =====
// Assertion macros for the invisible character filter.
`ifndef UTF8_INVISIBLE_CHAR_FILTER_DEFINES_SVH
`define UTF8_INVISIBLE_CHAR_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UCF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define UCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ucf_pkg.sv =====
package ucf_pkg;

	// Stripped byte counter width
	localparam int COUNT_BITS = 16;
	localparam int TOTAL_BITS = 16;

	// Command queue depth
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Byte codes
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_DEL   = 8'h7F;
	localparam logic [7:0] LEAD_E2    = 8'hE2;
	localparam logic [7:0] LEAD_EF    = 8'hEF;
	localparam logic [7:0] SEC_80     = 8'h80;
	localparam logic [7:0] SEC_81     = 8'h81;
	localparam logic [7:0] SEC_BB     = 8'hBB;
	localparam logic [7:0] THIRD_BF   = 8'hBF;

	// Scanner mode
	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_HELD1,
		MODE_HELD2,
		MODE_PASS
	} ucf_mode_t;

	// One queued request: up to three data bytes and an optional summary
	typedef struct packed {
		logic [1:0]            n_data;
		logic                  has_sum;
		logic [2:0][7:0]       data;
		logic [TOTAL_BITS-1:0] total;
		logic                  warn;
	} ucf_cmd_t;

	// Push side of the queue
	typedef struct packed {
		logic     valid;
		ucf_cmd_t cmd;
	} ucf_push_t;

endpackage

// ===== rtl/ucf_front.sv =====
module ucf_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [7:0]              in_byte,
	input  logic                    end_of_string,
	output logic                    in_stall,
	input  logic                    q_full,
	output ucf_pkg::ucf_push_t      push
);

	localparam int CW = ucf_pkg::COUNT_BITS;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	ucf_pkg::ucf_mode_t mode_q, mode_d;
	logic [1:0]    pass_q, pass_d;
	logic [7:0]    lead_q, lead_d;
	logic [7:0]    second_q, second_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          accept;
	logic [31:0]   cnt_ext;

	// Saturating add of a small count
	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] c, input logic [1:0] n);
		logic [CW:0] s;
		s = {1'b0, c} + (CW+1)'(n);
		return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CW-1:0];
	endfunction

	// Third byte of a held sequence that names an invisible character
	function automatic logic third_strips(input logic [7:0] l, input logic [7:0] s,
		input logic [7:0] x);
		logic r;
		r = 1'b0;
		if (l == ucf_pkg::LEAD_E2 && s == ucf_pkg::SEC_80)
			r = (x inside {[8'h8B:8'h8F], [8'hAA:8'hAE]});
		else if (l == ucf_pkg::LEAD_E2 && s == ucf_pkg::SEC_81)
			r = (x inside {[8'hA6:8'hA9]});
		else if (l == ucf_pkg::LEAD_EF && s == ucf_pkg::SEC_BB)
			r = (x == ucf_pkg::THIRD_BF);
		return r;
	endfunction

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ucf_pkg::MODE_IDLE;
			pass_q   <= '0;
			lead_q   <= '0;
			second_q <= '0;
			cnt_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pass_q   <= pass_d;
			lead_q   <= lead_d;
			second_q <= second_d;
			cnt_q    <= cnt_d;
		end
	end

	// Classify the byte and build the request
	always_comb begin
		mode_d   = mode_q;
		pass_d   = pass_q;
		lead_d   = lead_q;
		second_d = second_q;
		cnt_d    = cnt_q;
		push     = '0;
		cnt_ext  = '0;

		case (mode_q)
			ucf_pkg::MODE_PASS: begin
				push.cmd.data[0] = in_byte;
				push.cmd.n_data  = 2'd1;
				pass_d = pass_q - 2'd1;
				if (pass_q == 2'd1)
					mode_d = ucf_pkg::MODE_IDLE;
			end
			ucf_pkg::MODE_HELD1: begin
				if ((lead_q == ucf_pkg::LEAD_E2) ?
					(in_byte == ucf_pkg::SEC_80 || in_byte == ucf_pkg::SEC_81) :
					(in_byte == ucf_pkg::SEC_BB)) begin
					second_d = in_byte;
					mode_d   = ucf_pkg::MODE_HELD2;
				end else begin
					push.cmd.data[0] = lead_q;
					push.cmd.data[1] = in_byte;
					push.cmd.n_data  = 2'd2;
					pass_d = 2'd1;
					mode_d = ucf_pkg::MODE_PASS;
				end
			end
			ucf_pkg::MODE_HELD2: begin
				if (third_strips(lead_q, second_q, in_byte)) begin
					cnt_d = sat_add(cnt_q, 2'd3);
				end else begin
					push.cmd.data[0] = lead_q;
					push.cmd.data[1] = second_q;
					push.cmd.data[2] = in_byte;
					push.cmd.n_data  = 2'd3;
				end
				mode_d = ucf_pkg::MODE_IDLE;
			end
			default: begin
				if ((in_byte < ucf_pkg::BYTE_SPACE && in_byte != ucf_pkg::BYTE_TAB &&
					in_byte != ucf_pkg::BYTE_LF && in_byte != ucf_pkg::BYTE_CR) ||
					in_byte == ucf_pkg::BYTE_DEL) begin
					cnt_d = sat_add(cnt_q, 2'd1);
				end else if (in_byte == ucf_pkg::LEAD_E2 || in_byte == ucf_pkg::LEAD_EF) begin
					lead_d = in_byte;
					mode_d = ucf_pkg::MODE_HELD1;
				end else begin
					push.cmd.data[0] = in_byte;
					push.cmd.n_data  = 2'd1;
					// lead byte sets the number of unchecked followers
					if (in_byte[7:5] == 3'b110) begin
						pass_d = 2'd1;
						mode_d = ucf_pkg::MODE_PASS;
					end else if (in_byte[7:4] == 4'b1110) begin
						pass_d = 2'd2;
						mode_d = ucf_pkg::MODE_PASS;
					end else if (in_byte[7:3] == 5'b11110) begin
						pass_d = 2'd3;
						mode_d = ucf_pkg::MODE_PASS;
					end
				end
			end
		endcase

		// End of string: flush held bytes, add summary, clear state
		if (end_of_string) begin
			if (mode_d == ucf_pkg::MODE_HELD1) begin
				push.cmd.data[0] = lead_d;
				push.cmd.n_data  = 2'd1;
			end else if (mode_d == ucf_pkg::MODE_HELD2) begin
				push.cmd.data[0] = lead_d;
				push.cmd.data[1] = second_d;
				push.cmd.n_data  = 2'd2;
			end
			cnt_ext = 32'(cnt_d);
			push.cmd.has_sum = 1'b1;
			push.cmd.total   = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];
			push.cmd.warn    = (cnt_d != '0);
			mode_d   = ucf_pkg::MODE_IDLE;
			pass_d   = '0;
			lead_d   = '0;
			second_d = '0;
			cnt_d    = '0;
		end

		push.valid = accept && (push.cmd.n_data != 2'd0 || push.cmd.has_sum);
	end

endmodule

// ===== rtl/ucf_queue.sv =====
module ucf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  ucf_pkg::ucf_push_t push,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output ucf_pkg::ucf_cmd_t  head
);

	localparam int PW = ucf_pkg::QPTR_W;

	ucf_pkg::ucf_cmd_t mem_q [ucf_pkg::QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == (PW+1)'(ucf_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.cmd;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (PW+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (PW+1)'(1);
		end
	end

endmodule

// ===== rtl/ucf_back.sv =====
module ucf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ucf_pkg::ucf_cmd_t head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [7:0]        data_byte,
	output logic [15:0]       stripped_total,
	output logic              warning,
	output logic              run_last
);

	logic [1:0] pos_q;
	logic [2:0] n_rec;
	logic       fire;

	assign out_valid = !empty;
	assign fire      = out_valid && !out_stall;
	assign n_rec     = {1'b0, head.n_data} + {2'b00, head.has_sum};
	assign run_last  = ({1'b0, pos_q} == n_rec - 3'd1);
	assign pop       = fire && run_last;

	// Record position within the head request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= '0;
		else if (fire)
			pos_q <= run_last ? 2'd0 : pos_q + 2'd1;
	end

	// Data records first, summary last
	always_comb begin
		if (pos_q < head.n_data) begin
			kind           = 1'b0;
			data_byte      = head.data[pos_q];
			stripped_total = '0;
			warning        = 1'b0;
		end else begin
			kind           = 1'b1;
			data_byte      = '0;
			stripped_total = head.total;
			warning        = head.warn;
		end
	end

endmodule

// ===== rtl/utf8_invisible_char_filter.sv =====
// Strips C0 controls (except tab, LF, CR), DEL and the three-byte UTF-8
// forms of zero-width, BOM and bidi control characters from a byte stream.
// Input channel: in_valid/in_stall with in_byte and end_of_string, one
// string byte per request. Output channel: out_valid/out_stall with kind,
// data_byte, stripped_total, warning and run_last, one record per request.
// Kept bytes come out as data records; the final byte of a string adds a
// summary record with the saturating strip count and a warning flag.
// run_last marks the final record caused by one input byte.
// Throughput: one input byte per cycle while the four-entry request queue
// has room; records leave one at a time and out_stall holds them, so a
// byte that yields k records holds the output side until all are taken.
// Any request a byte makes is queued when it is accepted, behind earlier ones.
// E2/EF lead bytes are held until the following bytes decide them.
// Reset clears scanner state, strip count and the queue; no records pending.
// A stalled output holds its record; the queue fills and then in_stall
// rises until the receiver takes records again.
module utf8_invisible_char_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [15:0] stripped_total,
	output logic        warning,
	output logic        run_last
);

	`include "utf8_invisible_char_filter_defines.svh"

	ucf_pkg::ucf_push_t push;
	ucf_pkg::ucf_cmd_t  head;
	logic               q_full;
	logic               q_empty;
	logic               pop;

	// Scanner and classifier
	ucf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.in_stall      (in_stall),
		.q_full        (q_full),
		.push          (push)
	);

	// Request queue between the two sides
	ucf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.head   (head)
	);

	// Record emitter
	ucf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (q_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.data_byte      (data_byte),
		.stripped_total (stripped_total),
		.warning        (warning),
		.run_last       (run_last)
	);

	// Checks
	`UCF_ASSERT_SAME(a_sum_is_last, out_valid && kind, run_last, "summary record not last")
	`UCF_ASSERT_SAME(a_warn_matches, out_valid && kind, warning == (stripped_total != 16'd0), "warning does not match count")
	`UCF_ASSERT_SAME(a_data_clean, out_valid && !kind, stripped_total == 16'd0 && !warning, "data record carries summary fields")
	`UCF_ASSERT_NEXT(a_push_fills, push.valid && !q_full, !q_empty, "pushed request not visible")

endmodule

// ===== tb/utf8_invisible_char_filter_test.sv =====
module utf8_invisible_char_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Third-byte ranges that mark an invisible character
	localparam logic [7:0] ZW_LO   = 8'h8B;
	localparam logic [7:0] ZW_HI   = 8'h8F;
	localparam logic [7:0] BIDI_LO = 8'hAA;
	localparam logic [7:0] BIDI_HI = 8'hAE;
	localparam logic [7:0] ISO_LO  = 8'hA6;
	localparam logic [7:0] ISO_HI  = 8'hA9;

	// Cycles with no request moving on either side before giving up
	localparam int QUIET_LIMIT = 1000;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [15:0] total;
		logic        warn;
		logic        last;
	} filter_rec_t;

	// Scanner copy plus the queue of records still owed by the block
	class filter_scoreboard;
		ucf_pkg::ucf_mode_t             mode;
		logic [1:0]                     pass_left;
		logic [7:0]                     lead_b;
		logic [7:0]                     second_b;
		logic [ucf_pkg::COUNT_BITS-1:0] strip_cnt;
		filter_rec_t                    due_records[$];
		int                             errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			mode = ucf_pkg::MODE_IDLE;
			pass_left = '0;
			lead_b = '0;
			second_b = '0;
			strip_cnt = '0;
		endfunction

		function void add_strips(int n);
			logic [ucf_pkg::COUNT_BITS:0] sum;
			sum = strip_cnt + n;
			if (sum[ucf_pkg::COUNT_BITS])
				strip_cnt = '1;
			else
				strip_cnt = sum[ucf_pkg::COUNT_BITS-1:0];
		endfunction

		function void note(logic k, logic [7:0] d, logic [15:0] t, logic w);
			filter_rec_t rec;
			rec.kind = k;
			rec.data_byte = d;
			rec.total = t;
			rec.warn = w;
			rec.last = 1'b0;
			due_records.push_back(rec);
		endfunction

		function bit third_strips(logic [7:0] x);
			if (lead_b == ucf_pkg::LEAD_E2 && second_b == ucf_pkg::SEC_80)
				return (x >= ZW_LO && x <= ZW_HI) || (x >= BIDI_LO && x <= BIDI_HI);
			if (lead_b == ucf_pkg::LEAD_E2 && second_b == ucf_pkg::SEC_81)
				return x >= ISO_LO && x <= ISO_HI;
			return lead_b == ucf_pkg::LEAD_EF && second_b == ucf_pkg::SEC_BB &&
				x == ucf_pkg::THIRD_BF;
		endfunction

		// Advance the scanner by one accepted request
		function void take_byte(logic [7:0] b, logic eos);
			int          first;
			int unsigned cnt32;
			filter_rec_t rec;
			first = due_records.size();
			case (mode)
			ucf_pkg::MODE_PASS: begin
				note(1'b0, b, 16'h0, 1'b0);
				pass_left = pass_left - 2'd1;
				if (pass_left == 2'd0)
					mode = ucf_pkg::MODE_IDLE;
			end
			ucf_pkg::MODE_HELD1: begin
				if (lead_b == ucf_pkg::LEAD_E2 ?
						(b == ucf_pkg::SEC_80 || b == ucf_pkg::SEC_81) :
						(b == ucf_pkg::SEC_BB)) begin
					second_b = b;
					mode = ucf_pkg::MODE_HELD2;
				end else begin
					// second byte breaks the pattern: both go out, one more passes
					note(1'b0, lead_b, 16'h0, 1'b0);
					note(1'b0, b, 16'h0, 1'b0);
					pass_left = 2'd1;
					mode = ucf_pkg::MODE_PASS;
				end
			end
			ucf_pkg::MODE_HELD2: begin
				if (third_strips(b)) begin
					add_strips(3);
				end else begin
					note(1'b0, lead_b, 16'h0, 1'b0);
					note(1'b0, second_b, 16'h0, 1'b0);
					note(1'b0, b, 16'h0, 1'b0);
				end
				mode = ucf_pkg::MODE_IDLE;
			end
			default: begin
				if ((b < ucf_pkg::BYTE_SPACE && b != ucf_pkg::BYTE_TAB &&
						b != ucf_pkg::BYTE_LF && b != ucf_pkg::BYTE_CR) ||
						b == ucf_pkg::BYTE_DEL) begin
					add_strips(1);
				end else if (b == ucf_pkg::LEAD_E2 || b == ucf_pkg::LEAD_EF) begin
					lead_b = b;
					mode = ucf_pkg::MODE_HELD1;
				end else begin
					note(1'b0, b, 16'h0, 1'b0);
					// other lead bytes fix how many bytes pass unchecked
					if (b[7:5] == 3'b110) begin
						pass_left = 2'd1;
						mode = ucf_pkg::MODE_PASS;
					end else if (b[7:4] == 4'b1110) begin
						pass_left = 2'd2;
						mode = ucf_pkg::MODE_PASS;
					end else if (b[7:3] == 5'b11110) begin
						pass_left = 2'd3;
						mode = ucf_pkg::MODE_PASS;
					end
				end
			end
			endcase

			// End of string: flush held bytes, drop pending pass, then summary
			if (eos) begin
				if (mode == ucf_pkg::MODE_HELD1) begin
					note(1'b0, lead_b, 16'h0, 1'b0);
				end else if (mode == ucf_pkg::MODE_HELD2) begin
					note(1'b0, lead_b, 16'h0, 1'b0);
					note(1'b0, second_b, 16'h0, 1'b0);
				end
				cnt32 = strip_cnt;
				note(1'b1, 8'h00, cnt32 > 32'hFFFF ? 16'hFFFF : 16'(cnt32), |strip_cnt);
				clear();
			end

			if (due_records.size() > first) begin
				rec = due_records.pop_back();
				rec.last = 1'b1;
				due_records.push_back(rec);
			end
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void match_record(logic k, logic [7:0] d, logic [15:0] t, logic w,
				logic l);
			filter_rec_t want;
			if (due_records.size() == 0) begin
				$error("record with nothing due: kind %0b data 0x%0h total %0d", k, d, t);
				errors++;
				return;
			end
			want = due_records.pop_front();
			check_field("kind", 16'(want.kind), 16'(k));
			check_field("data_byte", 16'(want.data_byte), 16'(d));
			check_field("stripped_total", want.total, t);
			check_field("warning", 16'(want.warn), 16'(w));
			check_field("run_last", 16'(want.last), 16'(l));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        end_of_string;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [7:0]  data_byte;
	logic [15:0] stripped_total;
	logic        warning;
	logic        run_last;

	filter_scoreboard board;
	logic [7:0]       text_buf[$];
	bit               calm;
	int               gap_pct;
	int               quiet;

	utf8_invisible_char_filter DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.end_of_string  (end_of_string),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.data_byte      (data_byte),
		.stripped_total (stripped_total),
		.warning        (warning),
		.run_last       (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Present one request, with an optional idle burst first
	task automatic send_byte(input logic [7:0] b, input logic eos);
		int gap;
		gap = (!calm && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_byte = b;
		end_of_string = eos;
		do @(posedge clk); while (in_stall);
		board.take_byte(b, eos);
	endtask

	// Send text_buf as one string; the idle rate changes per string
	task automatic send_text();
		case ($urandom_range(0, 2))
		0: gap_pct = 0;
		1: gap_pct = 10;
		default: gap_pct = 35;
		endcase
		foreach (text_buf[i])
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	// Random string built mostly from well-formed tokens, cut at a random length
	function automatic void make_text();
		int         goal;
		logic [7:0] lead;
		logic [7:0] second;
		goal = $urandom_range(1, 12);
		text_buf.delete();
		while (text_buf.size() < goal) begin
			case ($urandom_range(0, 9))
			0, 1, 2: text_buf.push_back(8'($urandom_range(32'h20, 32'h7E)));
			3: text_buf.push_back($urandom_range(0, 3) == 0 ? ucf_pkg::BYTE_DEL :
					8'($urandom_range(0, 31)));
			4: begin
				case ($urandom_range(0, 3))
				0: text_buf = {text_buf, ucf_pkg::LEAD_E2, ucf_pkg::SEC_80,
						8'($urandom_range(ZW_LO, ZW_HI))};
				1: text_buf = {text_buf, ucf_pkg::LEAD_E2, ucf_pkg::SEC_80,
						8'($urandom_range(BIDI_LO, BIDI_HI))};
				2: text_buf = {text_buf, ucf_pkg::LEAD_E2, ucf_pkg::SEC_81,
						8'($urandom_range(ISO_LO, ISO_HI))};
				default: text_buf = {text_buf, ucf_pkg::LEAD_EF, ucf_pkg::SEC_BB,
						ucf_pkg::THIRD_BF};
				endcase
			end
			5: begin
				// near misses around the invisible forms
				lead = $urandom_range(0, 1) ? ucf_pkg::LEAD_E2 : ucf_pkg::LEAD_EF;
				case ($urandom_range(0, 4))
				0: second = ucf_pkg::SEC_80;
				1: second = ucf_pkg::SEC_81;
				2: second = ucf_pkg::SEC_BB;
				3: second = 8'($urandom_range(32'h80, 32'hBF));
				default: second = 8'($urandom);
				endcase
				text_buf = {text_buf, lead, second, 8'($urandom_range(32'h80, 32'hBF))};
			end
			6: text_buf = {text_buf, 8'($urandom_range(32'hC2, 32'hDF)),
					8'($urandom_range(32'h80, 32'hBF))};
			7: text_buf = {text_buf, 8'($urandom_range(32'hE0, 32'hEF)),
					8'($urandom_range(32'h80, 32'hBF)), 8'($urandom_range(32'h80, 32'hBF))};
			8: text_buf = {text_buf, 8'($urandom_range(32'hF0, 32'hF7)),
					8'($urandom_range(32'h80, 32'hBF)), 8'($urandom_range(32'h80, 32'hBF)),
					8'($urandom_range(0, 255))};
			default: text_buf.push_back(8'($urandom));
			endcase
		end
		while (text_buf.size() > goal)
			void'(text_buf.pop_back());
	endfunction

	// Receiver stalls in bursts; the burst rate is redrawn periodically
	initial begin
		int burst;
		int stall_pct;
		int tick;
		out_stall = 1'b0;
		burst = 0;
		stall_pct = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (tick % 32 == 0)
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
			if (calm || !arst_n) begin
				out_stall = 1'b0;
			end else if (burst > 0) begin
				out_stall = 1'b1;
				burst--;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				out_stall = 1'b1;
				burst = $urandom_range(0, 3);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.match_record(kind, data_byte, stripped_total, warning, run_last);
	end

	// Watchdog on cycles where no request moves
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("utf8_invisible_char_filter_test NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		end_of_string = 1'b0;
		calm = 1'b0;
		gap_pct = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// controls kept and stripped, stray high byte ends the string
		text_buf = '{8'h00, ucf_pkg::BYTE_LF, ucf_pkg::BYTE_TAB, ucf_pkg::BYTE_CR,
				ucf_pkg::BYTE_DEL, ucf_pkg::BYTE_SPACE, 8'hFF};
		send_text();
		// zero-width and BOM stripped, broken second byte, broken third at the end
		text_buf = '{ucf_pkg::LEAD_E2, ucf_pkg::SEC_80, ZW_LO, ucf_pkg::LEAD_EF,
				ucf_pkg::SEC_BB, ucf_pkg::THIRD_BF, ucf_pkg::LEAD_E2, 8'h41, 8'h05,
				ucf_pkg::LEAD_E2, ucf_pkg::SEC_80, 8'h90};
		send_text();
		// four-byte sequence cut short, pass still pending
		text_buf = '{8'hF0, 8'h9F, 8'h01};
		send_text();
		// two bytes held at the end
		text_buf = '{ucf_pkg::LEAD_EF, ucf_pkg::SEC_BB};
		send_text();
		// one byte held at the end
		text_buf = '{ucf_pkg::LEAD_E2};
		send_text();
		// string of one stripped byte
		text_buf = '{8'h1F};
		send_text();

		// random strings with idling on both sides
		for (int sent = 0; sent < 110; sent += text_buf.size()) begin
			make_text();
			send_text();
		end

		// closing stretch with no idling
		calm = 1'b1;
		for (int sent = 0; sent < 40; sent += text_buf.size()) begin
			make_text();
			send_text();
		end
		@(negedge clk);
		in_valid = 1'b0;

		while (board.due_records.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("utf8_invisible_char_filter_test OK");
		else
			$display("utf8_invisible_char_filter_test NOT OK");
		$finish;
	end

endmodule
